@@ rtl/stt_pkg.sv @@
`timescale 1ns / 1ps

package stt_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;
    localparam int TOKEN_OFF_BITS      = 16;
    localparam int OUTQ_DEPTH          = 4;

    typedef enum logic [3:0] {
        KIND_NUMBER      = 4'd0,
        KIND_IDENT       = 4'd1,
        KIND_MINUS       = 4'd2,
        KIND_MINUS_MINUS = 4'd3,
        KIND_COLON       = 4'd4,
        KIND_COMMA       = 4'd5,
        KIND_ASTERISK    = 4'd6,
        KIND_ARROW       = 4'd7,
        KIND_STRING      = 4'd8,
        KIND_END         = 4'd9,
        KIND_ERROR       = 4'd10
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_UNEXPECTED   = 2'd1,
        ERR_UNTERMINATED = 2'd2,
        ERR_EMPTY        = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        SCAN_IDLE   = 3'd0,
        SCAN_IDENT  = 3'd1,
        SCAN_NUMBER = 3'd2,
        SCAN_MINUS  = 3'd3,
        SCAN_STRING = 3'd4
    } t_scan;

    // keyword match progress: one code per prefix of fn, begin, end
    typedef enum logic [3:0] {
        KW_START = 4'd0,
        KW_F     = 4'd1,
        KW_FN    = 4'd2,
        KW_B     = 4'd3,
        KW_BE    = 4'd4,
        KW_BEG   = 4'd5,
        KW_BEGI  = 4'd6,
        KW_BEGIN = 4'd7,
        KW_E     = 4'd8,
        KW_EN    = 4'd9,
        KW_END   = 4'd10,
        KW_DEAD  = 4'd15
    } t_kw;

    typedef struct packed {
        logic       mode;
        logic [7:0] ch;
    } t_in_item;

    typedef struct packed {
        logic [3:0]                token_kind;
        logic [1:0]                error_code;
        logic [TOKEN_OFF_BITS-1:0] start_offset;
        logic [TOKEN_OFF_BITS-1:0] end_offset;
        logic                      keyword_flag;
        logic                      last_of_run;
    } t_token;

    function automatic logic f_is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic f_is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic f_is_ident_char(logic [7:0] c);
        return f_is_alpha(c) || f_is_digit(c) || (c == "_");
    endfunction

    function automatic logic f_is_space(logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic t_kw f_kw_next(t_kw st, logic [7:0] c);
        t_kw nx;
        nx = KW_DEAD;
        case (st)
            KW_START: begin
                if (c == "f") nx = KW_F;
                else if (c == "b") nx = KW_B;
                else if (c == "e") nx = KW_E;
            end
            KW_F:    if (c == "n") nx = KW_FN;
            KW_B:    if (c == "e") nx = KW_BE;
            KW_BE:   if (c == "g") nx = KW_BEG;
            KW_BEG:  if (c == "i") nx = KW_BEGI;
            KW_BEGI: if (c == "n") nx = KW_BEGIN;
            KW_E:    if (c == "n") nx = KW_EN;
            KW_EN:   if (c == "d") nx = KW_END;
            default: nx = KW_DEAD;
        endcase
        return nx;
    endfunction

endpackage

@@ rtl/stt_outq.sv @@
`timescale 1ns / 1ps

module stt_outq
    import stt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_one,
    input  logic   i_push_two,
    input  t_token i_push_data0,
    input  t_token i_push_data1,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_stall,
    output t_token o_data
);

    localparam int PTR_BITS = $clog2(OUTQ_DEPTH);
    localparam int CNT_BITS = $clog2(OUTQ_DEPTH + 1);

    t_token              r_mem [OUTQ_DEPTH];
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                pop;
    logic [PTR_BITS-1:0] wr_ptr_p1;

    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rd_ptr];
    // room for two results is kept free for the next transaction
    assign o_full    = (r_count > CNT_BITS'(OUTQ_DEPTH - 2));
    assign pop       = o_valid & ~i_stall;
    assign wr_ptr_p1 = r_wr_ptr + PTR_BITS'(1);

    always_comb begin
        n_rd_ptr = pop ? (r_rd_ptr + PTR_BITS'(1)) : r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (i_push_two) begin
            n_wr_ptr = r_wr_ptr + PTR_BITS'(2);
            n_count  = r_count + CNT_BITS'(2);
        end else if (i_push_one) begin
            n_wr_ptr = wr_ptr_p1;
            n_count  = r_count + CNT_BITS'(1);
        end
        if (pop) begin
            n_count = n_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_one || i_push_two) begin
            r_mem[r_wr_ptr] <= i_push_data0;
        end
        if (i_push_two) begin
            r_mem[wr_ptr_p1] <= i_push_data1;
        end
    end

endmodule

@@ rtl/source_text_tokenizer.sv @@
`timescale 1ns / 1ps
// channel  | direction | valid       | stall       | payload
// ---------+-----------+-------------+-------------+------------------------
// input    | in        | i_in_valid  | o_in_stall  | i_in_data  (t_in_item)
// result   | out       | o_out_valid | i_out_stall | o_out_data (t_token)
//
// One byte or end marker per cycle while o_in_stall is low; its results are registered in the output queue.
// A transaction yields up to two results, queued in a 4-entry output queue.
// o_in_stall rises while the queue holds more than two results.
// Synchronous active-low reset clears scanner state and the queue.
// The end marker returns the scanner to its reset state.

module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_token   o_out_data
);

    localparam int OB      = OFFSET_BITS;
    localparam int EXT     = (OB > TOKEN_OFF_BITS) ? OB : TOKEN_OFF_BITS + 1;
    localparam logic [EXT-1:0] CLAMP = EXT'({TOKEN_OFF_BITS{1'b1}});

    t_scan          r_scan, n_scan;
    logic           r_esc, n_esc;
    logic [OB-1:0]  r_token_start, n_token_start;
    logic [OB-1:0]  r_byte_offset, n_byte_offset;
    t_kw            r_kw, n_kw;
    logic           r_halted, n_halted;
    logic           r_seen, n_seen;

    logic           in_acc;
    logic           q_full;
    logic [7:0]     c;
    logic [OB-1:0]  off, off_m1;

    logic           idle_has;
    t_token         idle_res;
    t_scan          idle_scan;
    logic           idle_set_start;
    logic           idle_halt;
    logic           idle_kw_set;

    t_token         res0, res1;
    logic [1:0]     res_n;
    t_token         word_res;

    function automatic t_token f_put(t_kind kind, t_err code, logic [OB-1:0] s,
                                     logic [OB-1:0] e, logic kw);
        logic [OB-1:0]  e_fix;
        logic [EXT-1:0] s_x, e_x;
        t_token         t;
        e_fix          = (e < s) ? s : e;
        s_x            = EXT'(s);
        e_x            = EXT'(e_fix);
        t.token_kind   = kind;
        t.error_code   = code;
        t.start_offset = (s_x > CLAMP) ? {TOKEN_OFF_BITS{1'b1}} : s_x[TOKEN_OFF_BITS-1:0];
        t.end_offset   = (e_x > CLAMP) ? {TOKEN_OFF_BITS{1'b1}} : e_x[TOKEN_OFF_BITS-1:0];
        t.keyword_flag = kw;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    assign in_acc     = i_in_valid & ~o_in_stall;
    assign o_in_stall = q_full;
    assign c          = i_in_data.ch;
    assign off        = r_byte_offset;
    assign off_m1     = (off != '0) ? (off - OB'(1)) : '0;

    // open identifier or number closed at the previous byte
    always_comb begin
        if (r_scan == SCAN_IDENT) begin
            word_res = f_put(KIND_IDENT, ERR_NONE, r_token_start, off_m1,
                             (r_kw == KW_FN) || (r_kw == KW_BEGIN) || (r_kw == KW_END));
        end else begin
            word_res = f_put(KIND_NUMBER, ERR_NONE, r_token_start, off_m1, 1'b0);
        end
    end

    // byte scanned with no token open
    always_comb begin
        idle_has       = 1'b0;
        idle_res       = f_put(KIND_COLON, ERR_NONE, off, off, 1'b0);
        idle_scan      = SCAN_IDLE;
        idle_set_start = 1'b1;
        idle_halt      = 1'b0;
        idle_kw_set    = 1'b0;
        if (f_is_space(c)) begin
            idle_set_start = 1'b0;
        end else if (c == ":") begin
            idle_has       = 1'b1;
            idle_set_start = 1'b0;
        end else if (c == ",") begin
            idle_has       = 1'b1;
            idle_set_start = 1'b0;
            idle_res       = f_put(KIND_COMMA, ERR_NONE, off, off, 1'b0);
        end else if (c == "*") begin
            idle_has       = 1'b1;
            idle_set_start = 1'b0;
            idle_res       = f_put(KIND_ASTERISK, ERR_NONE, off, off, 1'b0);
        end else if (c == "-") begin
            idle_scan = SCAN_MINUS;
        end else if (c == "\"") begin
            idle_scan = SCAN_STRING;
        end else if (f_is_digit(c)) begin
            idle_scan = SCAN_NUMBER;
        end else if (f_is_alpha(c) || (c == "_")) begin
            idle_scan   = SCAN_IDENT;
            idle_kw_set = 1'b1;
        end else begin
            idle_has  = 1'b1;
            idle_halt = 1'b1;
            idle_res  = f_put(KIND_ERROR, ERR_UNEXPECTED, off, off, 1'b0);
        end
    end

    always_comb begin
        n_scan        = r_scan;
        n_esc         = r_esc;
        n_token_start = r_token_start;
        n_byte_offset = r_byte_offset;
        n_kw          = r_kw;
        n_halted      = r_halted;
        n_seen        = r_seen;
        res0          = word_res;
        res1          = idle_res;
        res_n         = 2'd0;

        if (i_in_data.mode) begin
            if (!r_seen) begin
                res0  = f_put(KIND_ERROR, ERR_EMPTY, '0, '0, 1'b0);
                res_n = 2'd1;
            end else if (!r_halted && (r_scan == SCAN_STRING)) begin
                res0  = f_put(KIND_ERROR, ERR_UNTERMINATED, r_token_start, off_m1, 1'b0);
                res_n = 2'd1;
            end else if (!r_halted &&
                         ((r_scan == SCAN_IDENT) || (r_scan == SCAN_NUMBER))) begin
                res1  = f_put(KIND_END, ERR_NONE, off, off, 1'b0);
                res_n = 2'd2;
            end else if (!r_halted && (r_scan == SCAN_MINUS)) begin
                res0  = f_put(KIND_MINUS, ERR_NONE, r_token_start, r_token_start, 1'b0);
                res1  = f_put(KIND_END, ERR_NONE, off, off, 1'b0);
                res_n = 2'd2;
            end else begin
                res0  = f_put(KIND_END, ERR_NONE, off, off, 1'b0);
                res_n = 2'd1;
            end
            n_scan        = SCAN_IDLE;
            n_esc         = 1'b0;
            n_token_start = '0;
            n_byte_offset = '0;
            n_kw          = KW_START;
            n_halted      = 1'b0;
            n_seen        = 1'b0;
        end else begin
            n_seen = 1'b1;
            if (r_byte_offset != {OB{1'b1}}) begin
                n_byte_offset = r_byte_offset + OB'(1);
            end
            if (!r_halted) begin
                case (r_scan)
                    SCAN_IDENT, SCAN_NUMBER: begin
                        if ((r_scan == SCAN_IDENT) && f_is_ident_char(c)) begin
                            n_kw = f_kw_next(r_kw, c);
                        end else if ((r_scan == SCAN_NUMBER) && f_is_digit(c)) begin
                            n_scan = SCAN_NUMBER;
                        end else begin
                            res_n    = idle_has ? 2'd2 : 2'd1;
                            n_scan   = idle_scan;
                            n_halted = idle_halt;
                            if (idle_set_start) n_token_start = off;
                            if (idle_scan == SCAN_STRING) n_esc = 1'b0;
                            if (idle_kw_set) n_kw = f_kw_next(KW_START, c);
                        end
                    end
                    SCAN_MINUS: begin
                        n_scan = SCAN_IDLE;
                        res_n  = 2'd1;
                        if (c == "-") begin
                            res0 = f_put(KIND_MINUS_MINUS, ERR_NONE, r_token_start, off, 1'b0);
                        end else if (c == ">") begin
                            res0 = f_put(KIND_ARROW, ERR_NONE, r_token_start, off, 1'b0);
                        end else begin
                            n_halted = 1'b1;
                            res0 = f_put(KIND_ERROR, ERR_UNEXPECTED, r_token_start, off, 1'b0);
                        end
                    end
                    SCAN_STRING: begin
                        if ((c == 8'd13) || (c == 8'd10)) begin
                            n_esc = r_esc;
                        end else if (r_esc) begin
                            n_esc = 1'b0;
                        end else if (c == "\\") begin
                            n_esc = 1'b1;
                        end else if (c == "\"") begin
                            n_scan = SCAN_IDLE;
                            res0   = f_put(KIND_STRING, ERR_NONE, r_token_start, off, 1'b0);
                            res_n  = 2'd1;
                        end
                    end
                    default: begin
                        res0     = idle_res;
                        res_n    = idle_has ? 2'd1 : 2'd0;
                        n_scan   = idle_scan;
                        n_halted = idle_halt;
                        if (idle_set_start) n_token_start = off;
                        if (idle_scan == SCAN_STRING) n_esc = 1'b0;
                        if (idle_kw_set) n_kw = f_kw_next(KW_START, c);
                    end
                endcase
            end
        end

        if (res_n == 2'd1) res0.last_of_run = 1'b1;
        if (res_n == 2'd2) res1.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan        <= SCAN_IDLE;
            r_esc         <= 1'b0;
            r_token_start <= '0;
            r_byte_offset <= '0;
            r_kw          <= KW_START;
            r_halted      <= 1'b0;
            r_seen        <= 1'b0;
        end else if (in_acc) begin
            r_scan        <= n_scan;
            r_esc         <= n_esc;
            r_token_start <= n_token_start;
            r_byte_offset <= n_byte_offset;
            r_kw          <= n_kw;
            r_halted      <= n_halted;
            r_seen        <= n_seen;
        end
    end

    stt_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_one   (in_acc && (res_n == 2'd1)),
        .i_push_two   (in_acc && (res_n == 2'd2)),
        .i_push_data0 (res0),
        .i_push_data1 (res1),
        .o_full       (q_full),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_data       (o_out_data)
    );

endmodule

@@ rtl/stt_checker.sv @@
`timescale 1ns / 1ps

module stt_checker
    import stt_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_token   o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result transaction changed");

    a_offsets_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.end_offset >= o_out_data.start_offset))
        else $error("token end offset below start offset");

    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.token_kind == KIND_ERROR) ==
                         (o_out_data.error_code != ERR_NONE)))
        else $error("error code does not match token kind");

    a_keyword_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.keyword_flag) |-> (o_out_data.token_kind == KIND_IDENT))
        else $error("keyword flag on non-identifier");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ test/source_text_tokenizer_test.sv @@
`timescale 1ns / 1ps

module source_text_tokenizer_test;
    import stt_pkg::*;

    localparam int          OFFSET_BITS = OFFSET_BITS_DEFAULT;
    localparam int unsigned OFFSET_MAX  = (1 << OFFSET_BITS) - 1;
    localparam int unsigned TOKEN_CLAMP = (1 << TOKEN_OFF_BITS) - 1;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          LONG_HOLD   = 80;
    localparam int          RANDOM_ITEMS = 1500;

    typedef enum logic [1:0] {
        STALL_NONE   = 2'd0,
        STALL_LIGHT  = 2'd1,
        STALL_HEAVY  = 2'd2,
        STALL_TOGGLE = 2'd3
    } t_stall_style;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_item i_in_data   = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_token   o_out_data;

    source_text_tokenizer #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_in_item pending_bytes[$];
    t_token   expected_tokens[$];

    int fail_count     = 0;
    int tokens_checked = 0;
    int items_accepted = 0;
    int items_queued   = 0;
    int sources_queued = 0;
    int hold_requests  = 0;

    // tokenizer shadow state
    t_scan       scan_st;
    bit          esc_pending;
    int unsigned tok_start;
    int unsigned byte_pos;
    t_kw         kw_state;
    bit          halted;
    bit          any_seen;

    t_token batch [2];
    int     batch_n;

    string kw_words [8] = '{"fn", "begin", "end", "be", "begins", "e", "fn_", "en"};

    function automatic bit is_dec(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic bit is_word_char(logic [7:0] c);
        return is_letter(c) || is_dec(c) || (c == "_");
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic int unsigned prev_pos(int unsigned p);
        return (p > 0) ? p - 1 : 0;
    endfunction

    function automatic t_kw kw_step(t_kw st, logic [7:0] c);
        case (st)
            KW_START: return (c == "f") ? KW_F : (c == "b") ? KW_B :
                             (c == "e") ? KW_E : KW_DEAD;
            KW_F:     return (c == "n") ? KW_FN : KW_DEAD;
            KW_B:     return (c == "e") ? KW_BE : KW_DEAD;
            KW_BE:    return (c == "g") ? KW_BEG : KW_DEAD;
            KW_BEG:   return (c == "i") ? KW_BEGI : KW_DEAD;
            KW_BEGI:  return (c == "n") ? KW_BEGIN : KW_DEAD;
            KW_E:     return (c == "n") ? KW_EN : KW_DEAD;
            KW_EN:    return (c == "d") ? KW_END : KW_DEAD;
            default:  return KW_DEAD;
        endcase
    endfunction

    task automatic clear_scanner();
        scan_st     = SCAN_IDLE;
        esc_pending = 1'b0;
        tok_start   = 0;
        byte_pos    = 0;
        kw_state    = KW_START;
        halted      = 1'b0;
        any_seen    = 1'b0;
    endtask

    task automatic add_token(t_kind k, t_err e, int unsigned s, int unsigned f, bit kw);
        t_token t;
        if (f < s) f = s;
        if (s > TOKEN_CLAMP) s = TOKEN_CLAMP;
        if (f > TOKEN_CLAMP) f = TOKEN_CLAMP;
        t.token_kind   = k;
        t.error_code   = e;
        t.start_offset = s[TOKEN_OFF_BITS-1:0];
        t.end_offset   = f[TOKEN_OFF_BITS-1:0];
        t.keyword_flag = kw;
        t.last_of_run  = 1'b0;
        batch[batch_n] = t;
        batch_n++;
    endtask

    task automatic close_word(int unsigned last);
        if (scan_st == SCAN_IDENT) begin
            add_token(KIND_IDENT, ERR_NONE, tok_start, last,
                      kw_state == KW_FN || kw_state == KW_BEGIN || kw_state == KW_END);
        end else begin
            add_token(KIND_NUMBER, ERR_NONE, tok_start, last, 1'b0);
        end
    endtask

    task automatic scan_fresh(logic [7:0] c, int unsigned p);
        scan_st = SCAN_IDLE;
        if (is_blank(c)) begin
        end else if (c == ":") begin
            add_token(KIND_COLON, ERR_NONE, p, p, 1'b0);
        end else if (c == ",") begin
            add_token(KIND_COMMA, ERR_NONE, p, p, 1'b0);
        end else if (c == "*") begin
            add_token(KIND_ASTERISK, ERR_NONE, p, p, 1'b0);
        end else begin
            tok_start = p;
            if (c == "-") begin
                scan_st = SCAN_MINUS;
            end else if (c == "\"") begin
                scan_st     = SCAN_STRING;
                esc_pending = 1'b0;
            end else if (is_dec(c)) begin
                scan_st = SCAN_NUMBER;
            end else if (is_letter(c) || c == "_") begin
                scan_st  = SCAN_IDENT;
                kw_state = kw_step(KW_START, c);
            end else begin
                halted = 1'b1;
                add_token(KIND_ERROR, ERR_UNEXPECTED, p, p, 1'b0);
            end
        end
    endtask

    task automatic tokenize_item(t_in_item it);
        int unsigned p;
        logic [7:0]  c;
        p       = byte_pos;
        c       = it.ch;
        batch_n = 0;
        if (it.mode) begin
            if (!any_seen) begin
                add_token(KIND_ERROR, ERR_EMPTY, 0, 0, 1'b0);
            end else if (!halted && scan_st == SCAN_STRING) begin
                add_token(KIND_ERROR, ERR_UNTERMINATED, tok_start, prev_pos(p), 1'b0);
            end else begin
                if (!halted) begin
                    if (scan_st == SCAN_IDENT || scan_st == SCAN_NUMBER)
                        close_word(prev_pos(p));
                    else if (scan_st == SCAN_MINUS)
                        add_token(KIND_MINUS, ERR_NONE, tok_start, tok_start, 1'b0);
                end
                add_token(KIND_END, ERR_NONE, p, p, 1'b0);
            end
            clear_scanner();
        end else begin
            any_seen = 1'b1;
            if (!halted) begin
                case (scan_st)
                    SCAN_IDENT: begin
                        if (is_word_char(c)) begin
                            kw_state = kw_step(kw_state, c);
                        end else begin
                            close_word(prev_pos(p));
                            scan_fresh(c, p);
                        end
                    end
                    SCAN_NUMBER: begin
                        if (!is_dec(c)) begin
                            close_word(prev_pos(p));
                            scan_fresh(c, p);
                        end
                    end
                    SCAN_MINUS: begin
                        scan_st = SCAN_IDLE;
                        if (c == "-") begin
                            add_token(KIND_MINUS_MINUS, ERR_NONE, tok_start, p, 1'b0);
                        end else if (c == ">") begin
                            add_token(KIND_ARROW, ERR_NONE, tok_start, p, 1'b0);
                        end else begin
                            halted = 1'b1;
                            add_token(KIND_ERROR, ERR_UNEXPECTED, tok_start, p, 1'b0);
                        end
                    end
                    SCAN_STRING: begin
                        // CR/LF inside a string leave the escape state alone
                        if (c != 8'h0D && c != 8'h0A) begin
                            if (esc_pending) begin
                                esc_pending = 1'b0;
                            end else if (c == "\\") begin
                                esc_pending = 1'b1;
                            end else if (c == "\"") begin
                                scan_st = SCAN_IDLE;
                                add_token(KIND_STRING, ERR_NONE, tok_start, p, 1'b0);
                            end
                        end
                    end
                    default: scan_fresh(c, p);
                endcase
            end
            if (byte_pos < OFFSET_MAX) byte_pos++;
        end
        if (batch_n > 0) batch[batch_n-1].last_of_run = 1'b1;
        for (int i = 0; i < batch_n; i++) expected_tokens = {expected_tokens, batch[i]};
    endtask

    // stimulus builders
    task automatic push_byte(logic [7:0] c);
        t_in_item it;
        it.mode = 1'b0;
        it.ch   = c;
        pending_bytes = {pending_bytes, it};
        items_queued++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_end();
        t_in_item it;
        it.mode = 1'b1;
        it.ch   = 8'($urandom_range(0, 255));
        pending_bytes = {pending_bytes, it};
        items_queued++;
        sources_queued++;
    endtask

    function automatic logic [7:0] rand_lead();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] rand_word_char();
        if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
        return rand_lead();
    endfunction

    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(0, 9);
        return (r < 5) ? 8'(9 + r) : " ";
    endfunction

    task automatic gen_string_body();
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 6))
                0, 1, 2: push_byte(rand_word_char());
                3: begin
                    push_byte("\\");
                    push_byte(8'($urandom_range(0, 255)));
                end
                4: push_byte($urandom_range(0, 1) ? 8'h0D : 8'h0A);
                5: push_byte(" ");
                default: push_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic gen_token();
        case ($urandom_range(0, 10))
            0, 1: push_text(kw_words[$urandom_range(0, 7)]);
            2, 3: begin
                push_byte(rand_lead());
                repeat ($urandom_range(0, 6)) push_byte(rand_word_char());
            end
            4: repeat ($urandom_range(1, 5)) push_byte(8'("0" + $urandom_range(0, 9)));
            5: push_byte(":");
            6: push_byte(",");
            7: push_byte("*");
            8: push_text($urandom_range(0, 1) ? "--" : "->");
            default: begin
                push_byte("\"");
                gen_string_body();
                push_byte("\"");
            end
        endcase
        if ($urandom_range(0, 2) != 0) begin
            repeat ($urandom_range(1, 2)) push_byte(rand_blank());
        end
    endtask

    task automatic gen_source();
        int n;
        n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
        repeat (n) begin
            gen_token();
            if ($urandom_range(0, 19) == 0) push_byte(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 9))
            0: push_byte("-");
            1: begin
                push_byte("\"");
                gen_string_body();
            end
            default: ;
        endcase
        push_end();
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // driver
    int unsigned gap_left   = 0;
    int unsigned burst_left = 0;

    always @(posedge i_clk) begin
        logic     take;
        logic     nxt_valid;
        t_in_item nxt_data;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            gap_left   = 0;
            burst_left = 0;
        end else begin
            take = i_in_valid && !o_in_stall;
            if (take) begin
                tokenize_item(i_in_data);
                items_accepted++;
            end
            nxt_valid = i_in_valid && !take;
            nxt_data  = i_in_data;
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_bytes.size() > 0) begin
                    nxt_data  = pending_bytes.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            i_in_valid <= nxt_valid;
            i_in_data  <= nxt_data;
        end
    end

    // receiver stall pattern
    t_stall_style stall_style      = STALL_NONE;
    int unsigned  stall_phase_left = 0;
    int unsigned  hold_left        = 0;
    int           hold_served      = 0;

    always @(posedge i_clk) begin
        logic nxt_stall;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (stall_phase_left == 0) begin
                stall_style      = t_stall_style'($urandom_range(0, 3));
                stall_phase_left = $urandom_range(20, 120);
            end else begin
                stall_phase_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_stall = 1'b1;
            end else begin
                case (stall_style)
                    STALL_LIGHT:  nxt_stall = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  nxt_stall = ($urandom_range(0, 9) < 7);
                    STALL_TOGGLE: nxt_stall = ~i_out_stall;
                    default:      nxt_stall = 1'b0;
                endcase
            end
            i_out_stall <= nxt_stall;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token kind=%0d err=%0d start=%0d end=%0d kw=%0b last=%0b",
                         $time, o_out_data.token_kind, o_out_data.error_code,
                         o_out_data.start_offset, o_out_data.end_offset,
                         o_out_data.keyword_flag, o_out_data.last_of_run);
                fail_count++;
            end else begin
                want = expected_tokens.pop_front();
                tokens_checked++;
                if (o_out_data.token_kind   !== want.token_kind   ||
                    o_out_data.error_code   !== want.error_code   ||
                    o_out_data.start_offset !== want.start_offset ||
                    o_out_data.end_offset   !== want.end_offset   ||
                    o_out_data.keyword_flag !== want.keyword_flag ||
                    o_out_data.last_of_run  !== want.last_of_run) begin
                    $display("%0t: mismatch expected kind=%0d err=%0d start=%0d end=%0d kw=%0b last=%0b",
                             $time, want.token_kind, want.error_code, want.start_offset,
                             want.end_offset, want.keyword_flag, want.last_of_run);
                    $display("%0t:          actual   kind=%0d err=%0d start=%0d end=%0d kw=%0b last=%0b",
                             $time, o_out_data.token_kind, o_out_data.error_code,
                             o_out_data.start_offset, o_out_data.end_offset,
                             o_out_data.keyword_flag, o_out_data.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d tokens outstanding",
                         $time, IDLE_LIMIT, expected_tokens.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        clear_scanner();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed sources
        push_end();
        push_text("fn:-");
        push_end();
        push_text("\"\\\n\"\"");
        push_end();
        push_text("-x");
        push_end();
        push_byte(8'hFF);
        push_byte(8'h00);
        push_end();
        push_text("7*->\"");
        push_end();
        wait_idle();

        // random sources, first half with a long output hold at the start
        while (items_queued < RANDOM_ITEMS / 2) gen_source();
        hold_requests++;
        wait_idle();
        while (items_queued < RANDOM_ITEMS) gen_source();
        wait_idle();
        repeat (10) @(posedge i_clk);

        if (expected_tokens.size() != 0) begin
            $display("%0t: %0d expected tokens never arrived", $time, expected_tokens.size());
            fail_count++;
        end
        $display("Ran %0d sources (%0d transactions in), %0d tokens compared, %0d failures",
                 sources_queued, items_accepted, tokens_checked, fail_count);
        $display("Covered every token kind and error, bursty input and a long output hold");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
